// File: sv/ebir_pkg.sv
// ----------------------------------------------------------------------------
// Euler body-to-inertial rotation package
// Shared widths, angle constants, stage latencies and types of the rotation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ebir_pkg;

   localparam int SINE_TABLE_DEPTH_DEF = 1024;

   localparam int ANGLE_W = 16;
   localparam int TRIG_W  = 16;
   localparam int ROM_W   = 15;
   localparam int VEC_W   = 32;
   localparam int ENTRY_W = 32;

   localparam int QUARTER_TURN  = 11520;
   localparam int HALF_TURN     = 23040;
   localparam int THREE_QUARTER = 34560;
   localparam int FULL_TURN     = 46080;

   localparam int ANGLE_LAT  = 6;
   localparam int MATRIX_LAT = 3;
   localparam int VECTOR_LAT = 3;

   typedef logic signed [TRIG_W-1:0]  trig_type;
   typedef logic signed [ENTRY_W-1:0] entry_type;

   typedef struct packed {
      trig_type sr;
      trig_type cr;
      trig_type sp;
      trig_type cp;
      trig_type sy;
      trig_type cy;
   } trig_set_type;

endpackage

// File: sv/ebir_sine_rom.sv
// ----------------------------------------------------------------------------
// Quarter-wave sine ROM
// Holds the Q0.15 sine of k/DEPTH of a right angle for k = 0..DEPTH, built
// from a Taylor series at elaboration. The read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ebir_sine_rom #(
   parameter int DEPTH = ebir_pkg::SINE_TABLE_DEPTH_DEF,
   localparam int AW = $clog2(DEPTH + 1)
) (
   input  logic                       clock,
   input  logic                       enable,
   input  logic [AW-1:0]              addr,
   output logic [ebir_pkg::ROM_W-1:0] data
);
   import ebir_pkg::*;

   localparam longint HALF_PI_Q30 = 64'd1686629713;
   localparam longint STEP_DEN    = 2 * longint'(DEPTH);

   typedef logic [ROM_W-1:0] rom_type [DEPTH+1];

   function automatic longint mul_q30(longint a, longint b);
      return (a * b) >>> 30;
   endfunction

   function automatic rom_type build_rom();
      rom_type t;
      longint  x;
      longint  term;
      longint  sum;
      for (int k = 0; k <= DEPTH; k++) begin
         x    = (longint'(k) * HALF_PI_Q30 * 2 + DEPTH) / STEP_DEN;
         term = x;
         sum  = x;
         term = mul_q30(mul_q30(term, x), x) / 6;
         sum  = sum - term;
         term = mul_q30(mul_q30(term, x), x) / 20;
         sum  = sum + term;
         term = mul_q30(mul_q30(term, x), x) / 42;
         sum  = sum - term;
         term = mul_q30(mul_q30(term, x), x) / 72;
         sum  = sum + term;
         term = mul_q30(mul_q30(term, x), x) / 110;
         sum  = sum - term;
         term = mul_q30(mul_q30(term, x), x) / 156;
         sum  = sum + term;
         if (sum < 0) begin
            sum = 0;
         end
         sum = (sum + 16384) >>> 15;
         if (sum > 32767) begin
            sum = 32767;
         end
         t[k] = sum[ROM_W-1:0];
      end
      return t;
   endfunction

   localparam rom_type ROM_DATA = build_rom();

   logic [ROM_W-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= ROM_DATA[addr];
      end
   end

   assign data = data_ff;

endmodule

// File: sv/ebir_trig_lookup.sv
// ----------------------------------------------------------------------------
// Sine and cosine lookup
// Wraps one angle, splits it into quadrant and residual, scales the residual
// to a table index and reads the quarter-wave ROM. Six register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ebir_trig_lookup #(
   parameter int DEPTH = ebir_pkg::SINE_TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              enable,
   input  logic signed [ebir_pkg::ANGLE_W-1:0] angle,
   output ebir_pkg::trig_type                sin_value,
   output ebir_pkg::trig_type                cos_value
);
   import ebir_pkg::*;

   localparam int     AW          = $clog2(DEPTH + 1);
   localparam longint NUM_MAX     = 64'd11520 * 2 * DEPTH + 64'd11520;
   localparam int     NW          = $clog2(NUM_MAX + 1);
   localparam int     RECIP_SHIFT = 32;
   localparam longint RECIP       = (64'd1 << RECIP_SHIFT) / HALF_TURN;
   localparam int     RW          = $clog2(RECIP + 1);
   localparam int     PW          = NW + RW;

   trig_type value [2];

   for (genvar g = 0; g < 2; g++) begin : g_lane
      localparam int OFFSET = g * QUARTER_TURN;

      logic signed [17:0] shifted;
      logic [15:0]        wrapped;
      logic [15:0]        rem;
      logic               odd_in;
      logic               neg_in;
      logic [13:0]        res_in;
      logic [PW-1:0]      prod;
      logic [NW-1:0]      left;
      logic [ROM_W-1:0]   rom_data;

      logic [13:0]        res_ff;
      logic [NW-1:0]      num_ff;
      logic [NW-1:0]      num2_ff;
      logic [AW-1:0]      quot_ff;
      logic [AW-1:0]      idx_ff;
      logic [4:0]         neg_ff;
      trig_type           value_ff;

      always_comb begin
         shifted = 18'(angle) + 18'(OFFSET);
         if (shifted < 0) begin
            wrapped = 16'(shifted + 18'(FULL_TURN));
         end else begin
            wrapped = 16'(shifted);
         end
         if (wrapped >= 16'(THREE_QUARTER)) begin
            rem    = wrapped - 16'(THREE_QUARTER);
            odd_in = 1'b1;
            neg_in = 1'b1;
         end else if (wrapped >= 16'(HALF_TURN)) begin
            rem    = wrapped - 16'(HALF_TURN);
            odd_in = 1'b0;
            neg_in = 1'b1;
         end else if (wrapped >= 16'(QUARTER_TURN)) begin
            rem    = wrapped - 16'(QUARTER_TURN);
            odd_in = 1'b1;
            neg_in = 1'b0;
         end else begin
            rem    = wrapped;
            odd_in = 1'b0;
            neg_in = 1'b0;
         end
         res_in = odd_in ? 14'(QUARTER_TURN) - rem[13:0] : rem[13:0];
         prod   = PW'(num_ff) * PW'(RECIP);
         left   = num2_ff - NW'(quot_ff) * NW'(HALF_TURN);
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            res_ff   <= res_in;
            num_ff   <= NW'(res_ff) * NW'(2 * DEPTH) + NW'(QUARTER_TURN);
            quot_ff  <= prod[RECIP_SHIFT +: AW];
            num2_ff  <= num_ff;
            idx_ff   <= (left >= NW'(HALF_TURN)) ? quot_ff + AW'(1) : quot_ff;
            neg_ff   <= {neg_ff[3:0], neg_in};
            value_ff <= neg_ff[4] ? -trig_type'({1'b0, rom_data})
                                  :  trig_type'({1'b0, rom_data});
         end
      end

      ebir_sine_rom #(
         .DEPTH (DEPTH)
      ) u_rom (
         .clock  (clock),
         .enable (enable),
         .addr   (idx_ff),
         .data   (rom_data)
      );

      assign value[g] = value_ff;
   end

   assign sin_value = value[0];
   assign cos_value = value[1];

endmodule

// File: sv/ebir_matrix.sv
// ----------------------------------------------------------------------------
// Direction-cosine matrix
// Forms the nine ZYX rotation entries from the six sines and cosines in
// three stages: pair products, triple products and sums, rounding to Q29.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ebir_matrix (
   input  logic                   clock,
   input  logic                   enable,
   input  ebir_pkg::trig_set_type trig,
   output ebir_pkg::entry_type    entry [9]
);
   import ebir_pkg::*;

   logic signed [31:0] cycp_ff, cysp_ff, sysp_ff, sycr_ff, sysr_ff;
   logic signed [31:0] sycp_ff, cycr_ff, cysr_ff, cpsr_ff, cpcr_ff;
   trig_type           sp_ff, sr_ff, cr_ff;
   logic signed [47:0] e_ff [9];
   logic signed [47:0] round_in [9];
   entry_type          m_ff [9];

   always_ff @(posedge clock) begin
      if (enable) begin
         cycp_ff <= trig.cy * trig.cp;
         cysp_ff <= trig.cy * trig.sp;
         sysp_ff <= trig.sy * trig.sp;
         sycr_ff <= trig.sy * trig.cr;
         sysr_ff <= trig.sy * trig.sr;
         sycp_ff <= trig.sy * trig.cp;
         cycr_ff <= trig.cy * trig.cr;
         cysr_ff <= trig.cy * trig.sr;
         cpsr_ff <= trig.cp * trig.sr;
         cpcr_ff <= trig.cp * trig.cr;
         sp_ff   <= trig.sp;
         sr_ff   <= trig.sr;
         cr_ff   <= trig.cr;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         e_ff[0] <= 48'(cycp_ff) <<< 15;
         e_ff[1] <= 48'(cysp_ff) * 48'(sr_ff) - (48'(sycr_ff) <<< 15);
         e_ff[2] <= 48'(cysp_ff) * 48'(cr_ff) + (48'(sysr_ff) <<< 15);
         e_ff[3] <= 48'(sycp_ff) <<< 15;
         e_ff[4] <= 48'(sysp_ff) * 48'(sr_ff) + (48'(cycr_ff) <<< 15);
         e_ff[5] <= 48'(sysp_ff) * 48'(cr_ff) - (48'(cysr_ff) <<< 15);
         e_ff[6] <= -(48'(sp_ff) <<< 30);
         e_ff[7] <= 48'(cpsr_ff) <<< 15;
         e_ff[8] <= 48'(cpcr_ff) <<< 15;
      end
   end

   // Rounding is half away from zero: negative values take one less bias.
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         round_in[i] = e_ff[i] + 48'sd32768 - 48'(e_ff[i][47]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 9; i++) begin
            m_ff[i] <= round_in[i][47:16];
         end
      end
   end

   assign entry = m_ff;

endmodule

// File: sv/ebir_vector.sv
// ----------------------------------------------------------------------------
// Matrix-vector product
// Multiplies the rotation matrix by the body vector, sums each row, rounds
// from Q29 and saturates to 32 bits. Three register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ebir_vector (
   input  logic                              clock,
   input  logic                              enable,
   input  ebir_pkg::entry_type               entry [9],
   input  logic signed [ebir_pkg::VEC_W:0]   body_x,
   input  logic signed [ebir_pkg::VEC_W-1:0] body_y,
   input  logic signed [ebir_pkg::VEC_W-1:0] body_z,
   output logic signed [ebir_pkg::VEC_W-1:0] inertial_x,
   output logic signed [ebir_pkg::VEC_W-1:0] inertial_y,
   output logic signed [ebir_pkg::VEC_W-1:0] inertial_z,
   output logic                              saturated
);
   import ebir_pkg::*;

   logic signed [64:0]      p_ff [9];
   logic signed [66:0]      acc_ff [3];
   logic signed [66:0]      round_in [3];
   logic signed [37:0]      rounded [3];
   logic signed [VEC_W-1:0] clip_in [3];
   logic [2:0]              over_in;
   logic signed [VEC_W-1:0] out_ff [3];
   logic                    sat_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 3; i++) begin
            p_ff[3*i]   <= 65'(entry[3*i])   * 65'(body_x);
            p_ff[3*i+1] <= 65'(entry[3*i+1]) * 65'(body_y);
            p_ff[3*i+2] <= 65'(entry[3*i+2]) * 65'(body_z);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 3; i++) begin
            acc_ff[i] <= 67'(p_ff[3*i]) + 67'(p_ff[3*i+1]) + 67'(p_ff[3*i+2]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         round_in[i] = acc_ff[i] + (67'sd1 <<< 28) - 67'(acc_ff[i][66]);
         rounded[i]  = round_in[i][66:29];
         if (!rounded[i][37] && (rounded[i][36:31] != 6'b000000)) begin
            clip_in[i] = {1'b0, {(VEC_W-1){1'b1}}};
            over_in[i] = 1'b1;
         end else if (rounded[i][37] && (rounded[i][36:31] != 6'b111111)) begin
            clip_in[i] = {1'b1, {(VEC_W-1){1'b0}}};
            over_in[i] = 1'b1;
         end else begin
            clip_in[i] = rounded[i][VEC_W-1:0];
            over_in[i] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_ff <= clip_in;
         sat_ff <= |over_in;
      end
   end

   assign inertial_x = out_ff[0];
   assign inertial_y = out_ff[1];
   assign inertial_z = out_ff[2];
   assign saturated  = sat_ff;

endmodule

// File: sv/euler_body_to_inertial_rotation_top.sv
// ----------------------------------------------------------------------------
// Euler body-to-inertial rotation, top level
// Throughput: one request per cycle unless stalled, set by the fully pipelined datapath.
// The whole pipeline holds while a result is stalled at the output.
// Reset clears the valid bits only; the sine ROM needs no initialization.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module euler_body_to_inertial_rotation_top #(
   parameter int SINE_TABLE_DEPTH = ebir_pkg::SINE_TABLE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [ebir_pkg::ANGLE_W-1:0] req_roll_angle,
   input  logic signed [ebir_pkg::ANGLE_W-1:0] req_pitch_angle,
   input  logic signed [ebir_pkg::ANGLE_W-1:0] req_yaw_angle,
   input  logic signed [ebir_pkg::VEC_W-1:0]   req_body_x,
   input  logic signed [ebir_pkg::VEC_W-1:0]   req_body_y,
   input  logic signed [ebir_pkg::VEC_W-1:0]   req_body_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ebir_pkg::VEC_W-1:0]   rsp_inertial_x,
   output logic signed [ebir_pkg::VEC_W-1:0]   rsp_inertial_y,
   output logic signed [ebir_pkg::VEC_W-1:0]   rsp_inertial_z,
   output logic                                rsp_saturated
);
   import ebir_pkg::*;

   localparam int BODY_LAT = ANGLE_LAT + MATRIX_LAT;
   localparam int LATENCY  = BODY_LAT + VECTOR_LAT;

   logic                    enable;
   logic [LATENCY-1:0]      valid_ff;
   trig_set_type            trig;
   trig_type                roll_sin, roll_cos;
   trig_type                pitch_sin, pitch_cos;
   trig_type                yaw_sin, yaw_cos;
   entry_type               entry [9];
   logic signed [VEC_W:0]   bx_ff [BODY_LAT];
   logic signed [VEC_W-1:0] by_ff [BODY_LAT];
   logic signed [VEC_W-1:0] bz_ff [BODY_LAT];

   assign enable    = !(rsp_valid && rsp_stall);
   assign req_stall = !enable;
   assign rsp_valid = valid_ff[LATENCY-1];

   assign trig = '{sr: roll_sin, cr: roll_cos, sp: pitch_sin, cp: pitch_cos,
                   sy: yaw_sin, cy: yaw_cos};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[LATENCY-2:0], req_valid};
      end
   end

   // The body x axis points backwards, so its component is negated here.
   always_ff @(posedge clock) begin
      if (enable) begin
         bx_ff[0] <= -(33'(req_body_x));
         by_ff[0] <= req_body_y;
         bz_ff[0] <= req_body_z;
         for (int i = 1; i < BODY_LAT; i++) begin
            bx_ff[i] <= bx_ff[i-1];
            by_ff[i] <= by_ff[i-1];
            bz_ff[i] <= bz_ff[i-1];
         end
      end
   end

   ebir_trig_lookup #(.DEPTH(SINE_TABLE_DEPTH)) u_roll (
      .clock     (clock),
      .enable    (enable),
      .angle     (req_roll_angle),
      .sin_value (roll_sin),
      .cos_value (roll_cos)
   );

   ebir_trig_lookup #(.DEPTH(SINE_TABLE_DEPTH)) u_pitch (
      .clock     (clock),
      .enable    (enable),
      .angle     (req_pitch_angle),
      .sin_value (pitch_sin),
      .cos_value (pitch_cos)
   );

   ebir_trig_lookup #(.DEPTH(SINE_TABLE_DEPTH)) u_yaw (
      .clock     (clock),
      .enable    (enable),
      .angle     (req_yaw_angle),
      .sin_value (yaw_sin),
      .cos_value (yaw_cos)
   );

   ebir_matrix u_matrix (
      .clock  (clock),
      .enable (enable),
      .trig   (trig),
      .entry  (entry)
   );

   ebir_vector u_vector (
      .clock      (clock),
      .enable     (enable),
      .entry      (entry),
      .body_x     (bx_ff[BODY_LAT-1]),
      .body_y     (by_ff[BODY_LAT-1]),
      .body_z     (bz_ff[BODY_LAT-1]),
      .inertial_x (rsp_inertial_x),
      .inertial_y (rsp_inertial_y),
      .inertial_z (rsp_inertial_z),
      .saturated  (rsp_saturated)
   );

   localparam logic signed [VEC_W-1:0] VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};
   localparam logic signed [VEC_W-1:0] VEC_MIN = {1'b1, {(VEC_W-1){1'b0}}};

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_inertial_x == VEC_MAX || rsp_inertial_x == VEC_MIN ||
          rsp_inertial_y == VEC_MAX || rsp_inertial_y == VEC_MIN ||
          rsp_inertial_z == VEC_MAX || rsp_inertial_z == VEC_MIN))
      else $error("saturation flag without a clipped component");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> ($stable(valid_ff) && $stable(bx_ff[BODY_LAT-1])))
      else $error("pipeline moved while stalled");

endmodule
